@@ design/mtm_pkg.sv @@
// ----------------------------------------------------------------------------
// mtm_pkg: shared types and constants for the message tag matcher
// Event codes, opcodes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package mtm_pkg;

    localparam int LIST_DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        EV_STORED    = 3'd0,
        EV_DELIVERED = 3'd1,
        EV_TRUNCATED = 3'd2,
        EV_PASSED    = 3'd3,
        EV_OVERFLOW  = 3'd4
    } event_t;

    localparam logic OP_RECV = 1'b0;
    localparam logic OP_MSG  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DECIDE,
        ST_OUT
    } state_t;

    // List selector: posted tagged, unexpected tagged, posted plain, unexpected plain
    typedef enum logic [1:0] {
        LS_PT = 2'd0,
        LS_UT = 2'd1,
        LS_PP = 2'd2,
        LS_UP = 2'd3
    } list_t;

    typedef struct packed {
        logic load;     // capture the input item
        logic scan;     // compare one entry, advance index on a miss
        logic shift;    // move one entry up, advance index
        logic finish;   // form the result and update counts/append
        logic out_pop;  // result taken
    } cmd_t;

    typedef struct packed {
        logic scan_done;  // scan over (hit or end of list)
        logic hit;        // a match was found
        logic shift_done; // compaction complete
        logic direct;     // item needs no scan (pass through or plain)
    } sts_t;

endpackage

@@ design/message_tag_matcher.sv @@
// ----------------------------------------------------------------------------
// message_tag_matcher: posted receive / unexpected message tag matcher
// Matches receives and messages over four ordered lists.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)                           | tuser
//  s_axis  | in  | opcode, is_tagged, is_posted_send, match_tag,       | -
//          |     | ignore_mask, byte_length, has_buffer, buffer_handle,|
//          |     | message_id (196 bits, zero filled to 200)           |
//  m_axis  | out | event_res, out_message_id, out_buffer_handle,       | -
//          |     | copy_to_buffer, out_length (68 bits, filled to 72)  |
//
// One item at a time: a pass through or an unmatched item goes through capture,
// scan check, result and output; a tagged list scan compares the entries in
// turn; after a match, compaction moves the later entries up in turn, through
// the single list compare/move port.
// Reset clears the controller and the four list counts; entries need none.
// A stalled result holds the block; the next item is taken after transfer.
// ----------------------------------------------------------------------------
module message_tag_matcher #(
    parameter int LIST_DEPTH = mtm_pkg::LIST_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, is_tagged, is_posted_send, match_tag, ignore_mask,
    // byte_length, has_buffer, buffer_handle, message_id
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // event_res, out_message_id, out_buffer_handle, copy_to_buffer, out_length
    output logic [71:0]  m_tdata
);

    mtm_pkg::cmd_t cmd;
    mtm_pkg::sts_t sts;
    logic [2:0]  ev;
    logic [15:0] mid, bh;
    logic        cp;
    logic [31:0] len;

    mtm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .sts       (sts),
        .cmd       (cmd)
    );

    mtm_dpath #(.LIST_DEPTH(LIST_DEPTH)) u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .in_opcode          (s_tdata[0]),
        .in_is_tagged       (s_tdata[1]),
        .in_is_posted_send  (s_tdata[2]),
        .in_match_tag       (s_tdata[66:3]),
        .in_ignore_mask     (s_tdata[130:67]),
        .in_byte_length     (s_tdata[162:131]),
        .in_has_buffer      (s_tdata[163]),
        .in_buffer_handle   (s_tdata[179:164]),
        .in_message_id      (s_tdata[195:180]),
        .out_event_res      (ev),
        .out_message_id     (mid),
        .out_buffer_handle  (bh),
        .out_copy_to_buffer (cp),
        .out_length         (len)
    );

    assign m_tdata = {4'b0000, len, cp, bh, mid, ev};

`ifndef SYNTHESIS
    // Event code stays within the defined range
    a_ev_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= mtm_pkg::EV_OVERFLOW))
        else $error("bad event code");

    // No new item is taken while a result is pending
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");

    // Non-delivered results never copy to a buffer
    a_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2:0] != mtm_pkg::EV_DELIVERED)) |-> !m_tdata[35])
        else $error("copy flag on non-delivery");
`endif

endmodule

@@ design/mtm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtm_ctrl: sequencing controller for the message tag matcher
// Steps each item through capture, list scan, compaction and result.
// ----------------------------------------------------------------------------
module mtm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_ready,
    output logic           out_valid,
    input  mtm_pkg::sts_t  sts,
    output mtm_pkg::cmd_t  cmd
);

    mtm_pkg::state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mtm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            mtm_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = mtm_pkg::ST_SCAN;
                end
            end
            mtm_pkg::ST_SCAN: begin
                if (sts.direct) begin
                    state_next = sts.hit ? mtm_pkg::ST_SHIFT : mtm_pkg::ST_DECIDE;
                end else if (sts.scan_done) begin
                    state_next = sts.hit ? mtm_pkg::ST_SHIFT : mtm_pkg::ST_DECIDE;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            mtm_pkg::ST_SHIFT: begin
                if (sts.shift_done) begin
                    state_next = mtm_pkg::ST_DECIDE;
                end else begin
                    cmd.shift = 1'b1;
                end
            end
            mtm_pkg::ST_DECIDE: begin
                cmd.finish = 1'b1;
                state_next = mtm_pkg::ST_OUT;
            end
            mtm_pkg::ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    cmd.out_pop = 1'b1;
                    state_next  = mtm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mtm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/mtm_dpath.sv @@
// ----------------------------------------------------------------------------
// mtm_dpath: list storage, tag compare and result datapath
// Four ordered lists; one entry compared or moved per cycle.
// ----------------------------------------------------------------------------
module mtm_dpath #(
    parameter int LIST_DEPTH = mtm_pkg::LIST_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  mtm_pkg::cmd_t  cmd,
    output mtm_pkg::sts_t  sts,
    input  logic           in_opcode,
    input  logic           in_is_tagged,
    input  logic           in_is_posted_send,
    input  logic [63:0]    in_match_tag,
    input  logic [63:0]    in_ignore_mask,
    input  logic [31:0]    in_byte_length,
    input  logic           in_has_buffer,
    input  logic [15:0]    in_buffer_handle,
    input  logic [15:0]    in_message_id,
    output logic [2:0]     out_event_res,
    output logic [15:0]    out_message_id,
    output logic [15:0]    out_buffer_handle,
    output logic           out_copy_to_buffer,
    output logic [31:0]    out_length
);

    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    // Info word: length [31:0], id [47:32], has_buffer [48]
    logic [63:0] pt_val [LIST_DEPTH];
    logic [63:0] pt_msk [LIST_DEPTH];
    logic [48:0] pt_inf [LIST_DEPTH];
    logic [63:0] ut_val [LIST_DEPTH];
    logic [48:0] ut_inf [LIST_DEPTH];
    logic [48:0] pp_inf [LIST_DEPTH];
    logic [48:0] up_inf [LIST_DEPTH];

    logic [CW-1:0] pt_cnt_reg, ut_cnt_reg, pp_cnt_reg, up_cnt_reg;

    logic          op_reg, tagged_reg, psend_reg;
    logic [63:0]   tag_reg, mask_reg;
    logic [48:0]   info_reg;
    logic [CW-1:0] idx_reg;
    logic          hit_reg;
    logic [48:0]   hit_inf_reg;

    logic [2:0]    ev_reg;
    logic [15:0]   mid_reg, bh_reg;
    logic          cp_reg;
    logic [31:0]   len_reg;

    mtm_pkg::list_t srch_list, store_list;
    logic [CW-1:0]  srch_cnt, store_cnt;
    logic           passthru;
    logic [IW-1:0]  idx;
    logic [IW-1:0]  idx1;
    logic           agree;
    logic [48:0]    rinfo, minfo;

    assign idx      = idx_reg[IW-1:0];
    assign idx1     = IW'(idx_reg + CW'(1));
    assign passthru = (op_reg == mtm_pkg::OP_MSG) && !psend_reg;

    // Pick the list to search and the list to append to
    always_comb begin
        if (op_reg == mtm_pkg::OP_RECV) begin
            srch_list  = tagged_reg ? mtm_pkg::LS_UT : mtm_pkg::LS_UP;
            store_list = tagged_reg ? mtm_pkg::LS_PT : mtm_pkg::LS_PP;
        end else begin
            srch_list  = tagged_reg ? mtm_pkg::LS_PT : mtm_pkg::LS_PP;
            store_list = tagged_reg ? mtm_pkg::LS_UT : mtm_pkg::LS_UP;
        end
        case (srch_list)
            mtm_pkg::LS_PT: srch_cnt = pt_cnt_reg;
            mtm_pkg::LS_UT: srch_cnt = ut_cnt_reg;
            mtm_pkg::LS_PP: srch_cnt = pp_cnt_reg;
            mtm_pkg::LS_UP: srch_cnt = up_cnt_reg;
            default:        srch_cnt = '0;
        endcase
        case (store_list)
            mtm_pkg::LS_PT: store_cnt = pt_cnt_reg;
            mtm_pkg::LS_UT: store_cnt = ut_cnt_reg;
            mtm_pkg::LS_PP: store_cnt = pp_cnt_reg;
            mtm_pkg::LS_UP: store_cnt = up_cnt_reg;
            default:        store_cnt = '0;
        endcase
    end

    // Compare the entry under the index
    always_comb begin
        if (op_reg == mtm_pkg::OP_RECV) begin
            agree = ((ut_val[idx] & ~mask_reg) == (tag_reg & ~mask_reg));
        end else begin
            agree = ((tag_reg & ~pt_msk[idx]) == (pt_val[idx] & ~pt_msk[idx]));
        end
    end

    // Status: plain lists and pass through need no scan
    always_comb begin
        sts.direct     = passthru || !tagged_reg;
        sts.hit        = passthru ? 1'b0 : (tagged_reg ? hit_reg : (srch_cnt != '0));
        sts.scan_done  = hit_reg || (idx_reg >= srch_cnt);
        sts.shift_done = (CW'(idx_reg + CW'(1)) >= srch_cnt);
    end

    // Pairing operands
    always_comb begin
        if (op_reg == mtm_pkg::OP_RECV) begin
            rinfo = info_reg;
            minfo = hit_inf_reg;
        end else begin
            rinfo = hit_inf_reg;
            minfo = info_reg;
        end
    end

    // Capture, scan and compact
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= in_opcode;
            tagged_reg  <= in_is_tagged;
            psend_reg   <= in_is_posted_send;
            tag_reg     <= in_match_tag;
            mask_reg    <= in_ignore_mask;
            info_reg    <= {in_has_buffer,
                            (in_opcode == mtm_pkg::OP_RECV) ? in_buffer_handle : in_message_id,
                            in_byte_length};
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            // Plain lists pair with the head entry; grab it before compaction
            hit_inf_reg <= (in_opcode == mtm_pkg::OP_RECV) ? up_inf[0] : pp_inf[0];
        end else if (cmd.scan) begin
            if (agree) begin
                hit_reg     <= 1'b1;
                hit_inf_reg <= (op_reg == mtm_pkg::OP_RECV) ? ut_inf[idx] : pt_inf[idx];
            end else begin
                idx_reg <= idx_reg + CW'(1);
            end
        end else if (cmd.shift) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (cmd.shift) begin
            case (srch_list)
                mtm_pkg::LS_PT: begin
                    pt_val[idx] <= pt_val[idx1];
                    pt_msk[idx] <= pt_msk[idx1];
                    pt_inf[idx] <= pt_inf[idx1];
                end
                mtm_pkg::LS_UT: begin
                    ut_val[idx] <= ut_val[idx1];
                    ut_inf[idx] <= ut_inf[idx1];
                end
                mtm_pkg::LS_PP: pp_inf[idx] <= pp_inf[idx1];
                mtm_pkg::LS_UP: up_inf[idx] <= up_inf[idx1];
                default: ;
            endcase
        end
        // Append an unmatched item
        if (cmd.finish && !passthru && !sts.hit && (store_cnt < CW'(LIST_DEPTH))) begin
            case (store_list)
                mtm_pkg::LS_PT: begin
                    pt_val[store_cnt[IW-1:0]] <= tag_reg;
                    pt_msk[store_cnt[IW-1:0]] <= mask_reg;
                    pt_inf[store_cnt[IW-1:0]] <= info_reg;
                end
                mtm_pkg::LS_UT: begin
                    ut_val[store_cnt[IW-1:0]] <= tag_reg;
                    ut_inf[store_cnt[IW-1:0]] <= info_reg;
                end
                mtm_pkg::LS_PP: pp_inf[store_cnt[IW-1:0]] <= info_reg;
                mtm_pkg::LS_UP: up_inf[store_cnt[IW-1:0]] <= info_reg;
                default: ;
            endcase
        end
    end

    // Update list counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_cnt_reg <= '0;
            ut_cnt_reg <= '0;
            pp_cnt_reg <= '0;
            up_cnt_reg <= '0;
        end else if (cmd.finish && !passthru) begin
            if (sts.hit) begin
                case (srch_list)
                    mtm_pkg::LS_PT: pt_cnt_reg <= pt_cnt_reg - CW'(1);
                    mtm_pkg::LS_UT: ut_cnt_reg <= ut_cnt_reg - CW'(1);
                    mtm_pkg::LS_PP: pp_cnt_reg <= pp_cnt_reg - CW'(1);
                    mtm_pkg::LS_UP: up_cnt_reg <= up_cnt_reg - CW'(1);
                    default: ;
                endcase
            end else if (store_cnt < CW'(LIST_DEPTH)) begin
                case (store_list)
                    mtm_pkg::LS_PT: pt_cnt_reg <= pt_cnt_reg + CW'(1);
                    mtm_pkg::LS_UT: ut_cnt_reg <= ut_cnt_reg + CW'(1);
                    mtm_pkg::LS_PP: pp_cnt_reg <= pp_cnt_reg + CW'(1);
                    mtm_pkg::LS_UP: up_cnt_reg <= up_cnt_reg + CW'(1);
                    default: ;
                endcase
            end
        end
    end

    // Form the result
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            ev_reg  <= mtm_pkg::EV_STORED;
            mid_reg <= '0;
            bh_reg  <= '0;
            cp_reg  <= 1'b0;
            len_reg <= '0;
            if (passthru) begin
                ev_reg  <= mtm_pkg::EV_PASSED;
                mid_reg <= info_reg[47:32];
                len_reg <= info_reg[31:0];
            end else if (sts.hit) begin
                mid_reg <= minfo[47:32];
                bh_reg  <= rinfo[47:32];
                if (rinfo[31:0] >= minfo[31:0]) begin
                    ev_reg  <= mtm_pkg::EV_DELIVERED;
                    cp_reg  <= rinfo[48] & minfo[48];
                    len_reg <= minfo[31:0];
                end else begin
                    ev_reg <= mtm_pkg::EV_TRUNCATED;
                end
            end else if (store_cnt >= CW'(LIST_DEPTH)) begin
                ev_reg <= mtm_pkg::EV_OVERFLOW;
            end
        end
    end

    assign out_event_res      = ev_reg;
    assign out_message_id     = mid_reg;
    assign out_buffer_handle  = bh_reg;
    assign out_copy_to_buffer = cp_reg;
    assign out_length         = len_reg;

endmodule
